/* hw/rtl/ucfb_pkg.sv */
// Shared types and constants of the USB/CAN frame bridge.
`default_nettype none

package ucfb_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 16;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 4;
  localparam int CFG_IDX_W = 8;

  localparam logic [BYTE_W-1:0] START_FLAG_RST = 8'd2;
  localparam logic [BYTE_W-1:0] END_FLAG_RST = 8'd3;

  localparam logic [CFG_IDX_W-1:0] REG_START_FLAG = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_FLAG = 8'd1;

  localparam logic SRC_USB = 1'b0;
  localparam logic SRC_CAN = 1'b1;

  localparam logic PORT_USB = 1'b0;
  localparam logic PORT_CAN = 1'b1;

  localparam int CTRL_RX_BIT = 4;

  typedef enum logic [10:0] {
    ST_WAIT   = 11'b000_0000_0001,
    ST_ID     = 11'b000_0000_0010,
    ST_CTRL   = 11'b000_0000_0100,
    ST_TXDATA = 11'b000_0000_1000,
    ST_TXEND  = 11'b000_0001_0000,
    ST_RXDATA = 11'b000_0010_0000,
    ST_HEAD   = 11'b000_0100_0000,
    ST_RD     = 11'b000_1000_0000,
    ST_LOAD   = 11'b001_0000_0000,
    ST_TAIL   = 11'b010_0000_0000,
    ST_ERR    = 11'b100_0000_0000
  } ucfb_state_t;

  typedef enum logic [1:0] {
    SEL_START = 2'd0,
    SEL_PAY   = 2'd1,
    SEL_END   = 2'd2,
    SEL_ERR   = 2'd3
  } ucfb_sel_t;

  typedef struct packed {
    logic      ld_id;
    logic      ld_ctrl;
    logic      wr_pay;
    logic      cnt_inc;
    logic      cnt_clr;
    logic      emit;
    ucfb_sel_t sel;
  } ucfb_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
    logic ctl_rx;
    logic ctl_len0;
    logic len0;
    logic cnt_last;
    logic rx_mode;
    logic out_free;
  } ucfb_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ucfb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ucfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/ucfb_ctrl.sv */
// Frame sequencer of the bridge: parses the byte stream and drives result runs.
`default_nettype none

module ucfb_ctrl
  import ucfb_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_command,
  output logic           in_ready,
  input  wire ucfb_sts_t sts,
  output ucfb_cmd_t      cmd
);

  ucfb_state_t state_r, state_nxt;
  logic        acc;
  logic        usb_acc;
  logic        can_acc;

  always_comb begin
    in_ready = (state_r == ST_WAIT) || (state_r == ST_ID) || (state_r == ST_CTRL) ||
               (state_r == ST_TXDATA) || (state_r == ST_TXEND) || (state_r == ST_RXDATA);
  end

  assign acc     = in_valid && in_ready;
  assign usb_acc = acc && (in_command == SRC_USB);
  assign can_acc = acc && (in_command == SRC_CAN);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_START;
    case (state_r)
      ST_WAIT: begin
        if (usb_acc && sts.is_start) begin
          state_nxt = ST_ID;
        end
      end
      ST_ID: begin
        if (usb_acc) begin
          cmd.ld_id = 1'b1;
          state_nxt = ST_CTRL;
        end
      end
      ST_CTRL: begin
        if (usb_acc) begin
          cmd.ld_ctrl = 1'b1;
          cmd.cnt_clr = 1'b1;
          if (sts.ctl_rx) begin
            state_nxt = sts.ctl_len0 ? ST_HEAD : ST_RXDATA;
          end else begin
            state_nxt = sts.ctl_len0 ? ST_TXEND : ST_TXDATA;
          end
        end
      end
      ST_TXDATA: begin
        if (usb_acc) begin
          cmd.wr_pay = 1'b1;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_TXEND;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_TXEND: begin
        if (usb_acc) begin
          if (!sts.is_end) begin
            state_nxt = ST_ERR;
          end else if (sts.len0) begin
            state_nxt = ST_WAIT;
          end else begin
            state_nxt = ST_RD;
          end
        end
      end
      ST_RXDATA: begin
        if (can_acc) begin
          cmd.wr_pay = 1'b1;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_HEAD;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_HEAD: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_START;
          state_nxt = sts.len0 ? ST_TAIL : ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_PAY;
          if (sts.cnt_last) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = sts.rx_mode ? ST_TAIL : ST_WAIT;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_nxt   = ST_RD;
          end
        end
      end
      ST_TAIL: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_END;
          state_nxt = ST_WAIT;
        end
      end
      ST_ERR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_ERR;
          state_nxt = ST_WAIT;
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A result is only loaded into a free output slot.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result loaded into a busy output slot");

  // Payload is only written on an accepted input transfer.
  a_wr_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pay |-> acc)
    else $error("payload write without an input transfer");

endmodule

`default_nettype wire

/* hw/rtl/ucfb_dp.sv */
// Datapath of the bridge: registers, payload buffer, counter and output register.
`default_nettype none

module ucfb_dp
  import ucfb_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  input  wire ucfb_cmd_t            cmd,
  output ucfb_sts_t                 sts,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_port,
  output logic      [BYTE_W-1:0]    out_out_byte,
  output logic      [BYTE_W-1:0]    out_can_id,
  output logic                      out_last,
  output logic                      out_frame_error
);

  localparam int AddrW = $clog2(PAYLOAD_DEPTH);

  logic [BYTE_W-1:0] start_flag_r, end_flag_r;
  logic [BYTE_W-1:0] frame_id_r;
  logic              rx_mode_r;
  logic [CNT_W-1:0]  len_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic [AddrW-1:0]  addr;
  logic [BYTE_W-1:0] rdata;
  logic              out_valid_r, out_valid_nxt;
  logic              port_r, last_r, err_r;
  logic [BYTE_W-1:0] byte_r, id_r;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_port, emit_last;

  assign cnt_inc = cnt_r + CNT_W'(1);
  assign addr    = AddrW'(cnt_r);

  ucfb_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(PAYLOAD_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_pay),
    .waddr(addr),
    .wdata(in_data_byte),
    .raddr(addr),
    .rdata(rdata)
  );

  always_comb begin
    sts.is_start = (in_data_byte == start_flag_r);
    sts.is_end   = (in_data_byte == end_flag_r);
    sts.ctl_rx   = in_data_byte[CTRL_RX_BIT];
    sts.ctl_len0 = (in_data_byte[CNT_W-1:0] == '0);
    sts.len0     = (len_r == '0);
    sts.cnt_last = (cnt_inc == len_r);
    sts.rx_mode  = rx_mode_r;
    sts.out_free = !out_valid_r || out_ready;
  end

  always_comb begin
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_comb begin
    emit_byte = '0;
    emit_port = PORT_USB;
    emit_last = 1'b0;
    case (cmd.sel)
      SEL_START: begin
        emit_byte = start_flag_r;
      end
      SEL_PAY: begin
        emit_byte = rdata;
        emit_port = rx_mode_r ? PORT_USB : PORT_CAN;
        emit_last = !rx_mode_r && sts.cnt_last;
      end
      SEL_END: begin
        emit_byte = end_flag_r;
        emit_last = 1'b1;
      end
      SEL_ERR: begin
        emit_last = 1'b1;
      end
      default: begin
        emit_byte = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r <= START_FLAG_RST;
      end_flag_r   <= END_FLAG_RST;
      frame_id_r   <= '0;
      rx_mode_r    <= 1'b0;
      len_r        <= '0;
      cnt_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == REG_START_FLAG)) begin
        start_flag_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_END_FLAG)) begin
        end_flag_r <= cfg_data;
      end
      if (cmd.ld_id) begin
        frame_id_r <= in_data_byte;
      end
      if (cmd.ld_ctrl) begin
        rx_mode_r <= in_data_byte[CTRL_RX_BIT];
        len_r     <= in_data_byte[CNT_W-1:0];
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      port_r <= emit_port;
      byte_r <= emit_byte;
      id_r   <= frame_id_r;
      last_r <= emit_last;
      err_r  <= (cmd.sel == SEL_ERR);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_port        = port_r;
  assign out_out_byte    = byte_r;
  assign out_can_id      = id_r;
  assign out_last        = last_r;
  assign out_frame_error = err_r;

  // Payload writes stay inside the announced frame length.
  a_wr_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_pay |-> (cnt_r < len_r))
    else $error("payload write beyond frame length");

  // Payload reads stay inside the announced frame length.
  a_rd_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && (cmd.sel == SEL_PAY)) |-> (cnt_r < len_r))
    else $error("payload read beyond frame length");

endmodule

`default_nettype wire

/* hw/rtl/usb_can_frame_bridge_unit.sv */
// Top level of the USB/CAN frame bridge: sequencer plus datapath.
//
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_command, in_data_byte
// out_      output     out_valid / out_ready  out_port, out_out_byte, out_can_id,
//                                             out_last, out_frame_error
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An input byte is taken whenever in_valid is high while the bridge is parsing a frame.
// A frame that produces results holds off input for the length of its result
// run: each start or end flag is sent from its own state, and each payload byte goes
// through a read state and then a load state, set by the buffer's registered read port.
// Reset is synchronous and active low; the payload buffer is not cleared.
// When out_ready is low the output register holds its transfer and the run
// waits; configuration writes are always taken.
`default_nettype none

module usb_can_frame_bridge_unit
  import ucfb_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire logic [BYTE_W-1:0]    in_data_byte,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_port,
  output logic      [BYTE_W-1:0]    out_out_byte,
  output logic      [BYTE_W-1:0]    out_can_id,
  output logic                      out_last,
  output logic                      out_frame_error,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  ucfb_cmd_t cmd;
  ucfb_sts_t sts;

  // The flag registers can be written in any cycle.
  assign cfg_ready = 1'b1;

  // The sequencer walks the frame header, payload and trailer, and runs the
  // result sequence, if the frame has one, once a frame completes.
  ucfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the flags, frame header, payload buffer, byte counter
  // and the output register that parts the result side from the input side.
  ucfb_dp #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_port       (out_port),
    .out_out_byte   (out_out_byte),
    .out_can_id     (out_can_id),
    .out_last       (out_last),
    .out_frame_error(out_frame_error)
  );

endmodule

`default_nettype wire
